>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define NPCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define NPCM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/npcm_pkg.sv
// types, constants and helpers of the nearest palette colour match unit
package npcm_pkg;

    localparam int unsigned IDX_W   = 8;
    localparam int unsigned COL_W   = 8;
    localparam int unsigned DIST_W  = 18;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned INDEX_SPACE = 256;

    localparam logic [CNT_W-1:0]  COLORS_RESET  = 9'd256;
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 18'h3FFFF;
    localparam logic [DIST_W-1:0] MAX_REAL_DIST = 18'd195075;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_MAP  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t             command;
        logic [IDX_W-1:0] entry_index;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic             end_of_image;
    } pix_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic              last_pixel;
    } res_item_t;

    // token handed from cell to cell
    typedef struct packed {
        logic              valid;
        pix_item_t         item;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
    } token_t;

    // square of the absolute difference of two colour components
    function automatic logic [2*COL_W-1:0] sq_diff(
        input logic [COL_W-1:0] a,
        input logic [COL_W-1:0] b
    );
        logic [COL_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {{COL_W{1'b0}}, d} * {{COL_W{1'b0}}, d};
    endfunction

endpackage

>>> rtl/npcm_cell.sv
// one palette cell: holds one entry and refines the running best match
module npcm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [npcm_pkg::CNT_W-1:0]    colors,
    input  npcm_pkg::token_t              tok_in,
    output npcm_pkg::token_t              tok_out
);

    localparam logic [npcm_pkg::IDX_W-1:0] MY_INDEX   = npcm_pkg::IDX_W'(CELL_INDEX);
    localparam logic                       FIRST_CELL = (CELL_INDEX == 0);

    logic [3*npcm_pkg::COL_W-1:0]  entry_reg;
    logic [3*npcm_pkg::COL_W-1:0]  entry_next;
    npcm_pkg::token_t              tok_reg;
    npcm_pkg::token_t              tok_next;
    logic [npcm_pkg::DIST_W-1:0]   cell_dist;
    logic                          in_range;

    // squared distance between the passing pixel and this entry
    always_comb
    begin
        cell_dist = npcm_pkg::DIST_W'(npcm_pkg::sq_diff(tok_in.item.red,
                                                        entry_reg[23:16]))
                  + npcm_pkg::DIST_W'(npcm_pkg::sq_diff(tok_in.item.green,
                                                        entry_reg[15:8]))
                  + npcm_pkg::DIST_W'(npcm_pkg::sq_diff(tok_in.item.blue,
                                                        entry_reg[7:0]));
        in_range = ({1'b0, MY_INDEX} < colors);
    end

    // load absorbs at its cell, map updates the best match
    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        if (tok_in.valid)
        begin
            case (tok_in.item.command)
                npcm_pkg::CMD_LOAD:
                begin
                    if (tok_in.item.entry_index == MY_INDEX)
                    begin
                        entry_next     = {tok_in.item.red, tok_in.item.green,
                                          tok_in.item.blue};
                        tok_next.valid = 1'b0;
                    end
                end
                npcm_pkg::CMD_MAP:
                begin
                    if (in_range && (FIRST_CELL || (cell_dist < tok_in.best_distance)))
                    begin
                        tok_next.best_index    = MY_INDEX;
                        tok_next.best_distance = cell_dist;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // token register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    // palette entry, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/nearest_palette_color_match_unit.sv
// top level of the nearest palette colour match unit: cell chain and register
//
//  channel   direction   handshake              payload
//  pix       in          pix_valid/pix_stall    npcm_pkg::pix_item_t
//  res       out         res_valid/res_stall    npcm_pkg::res_item_t
//  cfg       in          cfg_write              cfg_data (colors_in_use)
//
// one transfer enters per cycle while pix_stall is low; a result leaves from the
// register of the last cell, after its pixel has passed every cell of the chain
// loads travel down the chain in order with pixels and are absorbed at their cell
// a stalled result freezes the whole chain, so pix_stall is high while a valid result is stalled
// reset clears the chain tokens and sets colors_in_use to 256; entries stay undefined
module nearest_palette_color_match_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  npcm_pkg::pix_item_t        pix_data,
    output logic                       res_valid,
    input  logic                       res_stall,
    output npcm_pkg::res_item_t        res_data,
    input  logic                       cfg_write,
    input  logic [npcm_pkg::CNT_W-1:0] cfg_data
);

    localparam int CELL_COUNT = (PALETTE_DEPTH < npcm_pkg::INDEX_SPACE) ?
                                PALETTE_DEPTH : npcm_pkg::INDEX_SPACE;

    logic [npcm_pkg::CNT_W-1:0] colors_reg;
    npcm_pkg::token_t           chain [CELL_COUNT+1];
    npcm_pkg::token_t           last_tok;
    logic                       en;

    // colour count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_reg <= npcm_pkg::COLORS_RESET;
        end
        else if (cfg_write)
        begin
            colors_reg <= cfg_data;
        end
    end

    // chain advances unless a result waits
    assign en        = !(res_valid && res_stall);
    assign pix_stall = !en;

    // token entering the chain
    always_comb
    begin
        chain[0].valid         = pix_valid;
        chain[0].item          = pix_data;
        chain[0].best_index    = '0;
        chain[0].best_distance = npcm_pkg::NO_MATCH_DIST;
    end

    // row of palette cells
    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        npcm_cell #(
            .CELL_INDEX(k)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .colors (colors_reg),
            .tok_in (chain[k]),
            .tok_out(chain[k+1])
        );
    end

    // result from the end of the chain, loads filtered out
    assign last_tok               = chain[CELL_COUNT];
    assign res_valid              = last_tok.valid &&
                                    (last_tok.item.command == npcm_pkg::CMD_MAP);
    assign res_data.best_index    = last_tok.best_index;
    assign res_data.best_distance = last_tok.best_distance;
    assign res_data.last_pixel    = last_tok.item.end_of_image;

endmodule

>>> rtl/npcm_checker.sv
// port checker of the nearest palette colour match unit and its bind
`include "assert_macros.svh"

module npcm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pix_stall,
    input logic                res_valid,
    input logic                res_stall,
    input npcm_pkg::res_item_t res_data
);

    // a stalled result holds
    `NPCM_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_data), "stalled result changed")

    // input stalls only behind a stalled result
    `NPCM_ASSERT(a_stall_cause, pix_stall |-> res_valid && res_stall, "input stalled without result stall")

    // a real distance never exceeds the largest rgb distance
    `NPCM_ASSERT(a_dist_bound, res_valid && (res_data.best_distance != npcm_pkg::NO_MATCH_DIST) |-> res_data.best_distance <= npcm_pkg::MAX_REAL_DIST, "distance out of range")

    // nothing comes out just after reset
    `NPCM_ASSERT_RST(a_reset_quiet, !rst_n |=> !res_valid, "result right after reset")

endmodule

bind nearest_palette_color_match_unit npcm_checker u_npcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_stall(pix_stall),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
);

>>> verif/nearest_palette_color_match_unit_test.sv
// self-checking testbench of the nearest palette colour match unit
module nearest_palette_color_match_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAIN_LATENCY = 256;
    localparam int SETTLE_CYCLES = CHAIN_LATENCY + 64;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 118;

    localparam npcm_pkg::cmd_t LOAD_CMD = npcm_pkg::CMD_LOAD;
    localparam npcm_pkg::cmd_t MAP_CMD  = npcm_pkg::CMD_MAP;
    localparam int             NO_MATCH = int'(npcm_pkg::NO_MATCH_DIST);
    localparam int             MAX_DIST = int'(npcm_pkg::MAX_REAL_DIST);

    typedef struct {
        int                  cfg;     // colour count written before the transfer, -1 for none
        npcm_pkg::pix_item_t px;
        bit                  typed;   // expected result given in the row
        npcm_pkg::res_item_t want;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          pix_valid;
    logic                          pix_stall;
    npcm_pkg::pix_item_t           pix_data;
    logic                          res_valid;
    logic                          res_stall;
    npcm_pkg::res_item_t           res_data;
    logic                          cfg_write;
    logic [npcm_pkg::CNT_W-1:0]    cfg_data;

    // predictor state: palette copy and active colour count
    logic [3*npcm_pkg::COL_W-1:0]  palette_mem [npcm_pkg::INDEX_SPACE];
    logic [npcm_pkg::CNT_W-1:0]    search_count;
    npcm_pkg::res_item_t           pending_matches [$];
    dir_row_t                      dir_rows [$];
    npcm_pkg::res_item_t           got_match;
    int                            mismatch_count;
    int                            cycle_count;
    bit                            send_burst;
    bit                            recv_burst;
    bit                            long_hold_req;

    nearest_palette_color_match_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // nearest entry among the searched ones, lowest index wins a tie
    function automatic npcm_pkg::res_item_t nearest_entry(input npcm_pkg::pix_item_t px);
        npcm_pkg::res_item_t          r;
        int                           n;
        int                           dr;
        int                           dg;
        int                           db;
        int                           d;
        int                           best_d;
        logic [3*npcm_pkg::COL_W-1:0] e;
        n = (search_count > npcm_pkg::CNT_W'(npcm_pkg::INDEX_SPACE)) ?
            int'(npcm_pkg::INDEX_SPACE) : int'(search_count);
        r.best_index    = '0;
        r.best_distance = npcm_pkg::NO_MATCH_DIST;
        r.last_pixel    = px.end_of_image;
        best_d          = -1;
        for (int k = 0; k < n; k++)
        begin
            e  = palette_mem[npcm_pkg::IDX_W'(k)];
            dr = int'(px.red)   - int'(e[23:16]);
            dg = int'(px.green) - int'(e[15:8]);
            db = int'(px.blue)  - int'(e[7:0]);
            d  = dr * dr + dg * dg + db * db;
            if (best_d < 0 || d < best_d)
            begin
                best_d          = d;
                r.best_index    = npcm_pkg::IDX_W'(k);
                r.best_distance = npcm_pkg::DIST_W'(d);
            end
        end
        return r;
    endfunction

    // random load or map, maps often close to an entry, loads sometimes duplicate one
    function automatic npcm_pkg::pix_item_t random_item();
        npcm_pkg::pix_item_t          px;
        int                           n;
        logic [3*npcm_pkg::COL_W-1:0] e;
        px.command      = ($urandom_range(0, 99) < 30) ? npcm_pkg::CMD_LOAD : npcm_pkg::CMD_MAP;
        px.entry_index  = npcm_pkg::IDX_W'($urandom);
        px.red          = npcm_pkg::COL_W'($urandom);
        px.green        = npcm_pkg::COL_W'($urandom);
        px.blue         = npcm_pkg::COL_W'($urandom);
        px.end_of_image = ($urandom_range(0, 7) == 0);
        n = (search_count > npcm_pkg::CNT_W'(npcm_pkg::INDEX_SPACE)) ?
            int'(npcm_pkg::INDEX_SPACE) : int'(search_count);
        if (px.command == npcm_pkg::CMD_LOAD && $urandom_range(0, 3) == 0)
        begin
            e = palette_mem[npcm_pkg::IDX_W'($urandom_range(0, npcm_pkg::INDEX_SPACE - 1))];
            {px.red, px.green, px.blue} = e;
        end
        else if (px.command == npcm_pkg::CMD_MAP && n > 0 && $urandom_range(0, 1) == 1)
        begin
            e        = palette_mem[npcm_pkg::IDX_W'($urandom_range(0, n - 1))];
            px.red   = e[23:16] ^ npcm_pkg::COL_W'($urandom_range(0, 1));
            px.green = e[15:8]  ^ npcm_pkg::COL_W'($urandom_range(0, 1));
            px.blue  = e[7:0]   ^ npcm_pkg::COL_W'($urandom_range(0, 1));
        end
        return px;
    endfunction

    // offer one transfer after a random gap (none in burst mode), update the predictor on acceptance
    task automatic send_item(input npcm_pkg::pix_item_t px, input bit typed,
                             input npcm_pkg::res_item_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        do @(posedge clk); while (pix_stall);
        if (px.command == npcm_pkg::CMD_LOAD)
            palette_mem[px.entry_index] = {px.red, px.green, px.blue};
        else
            pending_matches.push_back(typed ? want : nearest_entry(px));
    endtask

    // stop offering, wait for outstanding results and for loads still in the chain
    task automatic settle();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_colors(input int count);
        settle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= npcm_pkg::CNT_W'(count);
        @(negedge clk);
        cfg_write <= 1'b0;
        search_count = npcm_pkg::CNT_W'(count);
    endtask

    task automatic add_row(input int cfg, input npcm_pkg::cmd_t cmd, input int idx,
                           input int r, input int g, input int b, input bit eoi,
                           input bit typed, input int w_index, input int w_dist,
                           input bit w_last);
        dir_row_t row;
        row.cfg                = cfg;
        row.px.command         = cmd;
        row.px.entry_index     = npcm_pkg::IDX_W'(idx);
        row.px.red             = npcm_pkg::COL_W'(r);
        row.px.green           = npcm_pkg::COL_W'(g);
        row.px.blue            = npcm_pkg::COL_W'(b);
        row.px.end_of_image    = eoi;
        row.typed              = typed;
        row.want.best_index    = npcm_pkg::IDX_W'(w_index);
        row.want.best_distance = npcm_pkg::DIST_W'(w_dist);
        row.want.last_pixel    = w_last;
        dir_rows.push_back(row);
    endtask

    // receiver: random stall per result (none in burst mode), one long hold-off on request
    initial
    begin
        int hold;
        res_stall = 1'b0;
        forever
        begin
            hold = recv_burst ? 0 : $urandom_range(0, 7);
            if (long_hold_req)
            begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    // result check against the oldest pending match
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t: result expected none actual index %0d distance %0d last %0b",
                         $time, res_data.best_index, res_data.best_distance,
                         res_data.last_pixel);
                mismatch_count++;
            end
            else
            begin
                got_match = pending_matches.pop_front();
                if (res_data.best_index !== got_match.best_index)
                begin
                    $display("%0t: best_index expected %0d actual %0d", $time,
                             got_match.best_index, res_data.best_index);
                    mismatch_count++;
                end
                if (res_data.best_distance !== got_match.best_distance)
                begin
                    $display("%0t: best_distance expected %0d actual %0d", $time,
                             got_match.best_distance, res_data.best_distance);
                    mismatch_count++;
                end
                if (res_data.last_pixel !== got_match.last_pixel)
                begin
                    $display("%0t: last_pixel expected %0b actual %0b", $time,
                             got_match.last_pixel, res_data.last_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        npcm_pkg::pix_item_t px;
        int                  v;
        mismatch_count = 0;
        cycle_count    = 0;
        send_burst     = 1'b0;
        recv_burst     = 1'b0;
        long_hold_req  = 1'b0;
        search_count   = npcm_pkg::COLORS_RESET;
        rst_n          = 1'b0;
        pix_valid      = 1'b0;
        pix_data       = '0;
        cfg_write      = 1'b0;
        cfg_data       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // grey ramp in every entry, so any search reads written entries only
        for (int k = 0; k < npcm_pkg::INDEX_SPACE; k++)
        begin
            px = '{npcm_pkg::CMD_LOAD, npcm_pkg::IDX_W'(k), npcm_pkg::COL_W'(k),
                   npcm_pkg::COL_W'(k), npcm_pkg::COL_W'(k), k[0]};
            send_item(px, 1'b0, '0);
        end

        // directed rows: reset count, empty search, single entry, oversized counts, ties
        add_row( -1, MAP_CMD,    0,   0,   0,   0, 1'b0, 1'b1,   0, 0, 1'b0);
        add_row( -1, MAP_CMD,    0, 255, 255, 255, 1'b1, 1'b1, 255, 0, 1'b1);
        add_row( -1, MAP_CMD,  255, 255,   0,   0, 1'b0, 1'b0,   0, 0, 1'b0);
        add_row(  0, MAP_CMD,    0,   0,   0,   0, 1'b0, 1'b1,   0, NO_MATCH, 1'b0);
        add_row( -1, MAP_CMD,  255, 255, 255, 255, 1'b1, 1'b1,   0, NO_MATCH, 1'b1);
        add_row(  1, MAP_CMD,    0, 255, 255, 255, 1'b0, 1'b1,   0, MAX_DIST, 1'b0);
        add_row( -1, LOAD_CMD,   0, 255,   0, 255, 1'b1, 1'b0,   0, 0, 1'b0);
        add_row( -1, MAP_CMD,  255,   0, 255,   0, 1'b0, 1'b1,   0, MAX_DIST, 1'b0);
        add_row(511, MAP_CMD,    0,   1,   1,   1, 1'b0, 1'b1,   1, 0, 1'b0);
        add_row( -1, MAP_CMD,    0, 128, 128, 128, 1'b1, 1'b1, 128, 0, 1'b1);
        add_row( -1, LOAD_CMD,   2,   1,   1,   1, 1'b0, 1'b0,   0, 0, 1'b0);
        add_row( -1, MAP_CMD,    0,   2,   2,   2, 1'b0, 1'b1,   1, 3, 1'b0);
        add_row(257, MAP_CMD,    0,   0,   0,   0, 1'b1, 1'b1,   1, 3, 1'b1);
        add_row(  2, MAP_CMD,    0, 255, 255,   0, 1'b0, 1'b0,   0, 0, 1'b0);
        add_row( -1, LOAD_CMD, 255,   0,   0,   0, 1'b1, 1'b0,   0, 0, 1'b0);
        add_row(256, MAP_CMD,    0,   0,   0,   0, 1'b0, 1'b1, 255, 0, 1'b0);
        add_row( -1, MAP_CMD,   17, 127, 128, 129, 1'b1, 1'b0,   0, 0, 1'b0);
        add_row( -1, LOAD_CMD,   0, 255, 255, 255, 1'b0, 1'b0,   0, 0, 1'b0);
        add_row( -1, MAP_CMD,    0, 254, 255, 255, 1'b0, 1'b1,   0, 1, 1'b0);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg >= 0)
                write_colors(dir_rows[i].cfg);
            send_item(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, each at its own colour count
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       v = $urandom_range(1, 256);
                1, 9:    v = 256;
                2:       v = $urandom_range(257, 511);
                3:       v = $urandom_range(1, 8);
                4:       v = 1;
                6:       v = 0;
                7:       v = 511;
                8:       v = $urandom_range(2, 64);
                default: v = $urandom_range(1, 256);
            endcase
            write_colors(v);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (p == 2)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                px = random_item();
                send_item(px, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
